@@ src/shda_pkg.sv @@
`default_nettype none

package shda_pkg;

   // field widths
   localparam int MINUTE_W   = 6;
   localparam int HOUR_W     = 5;
   localparam int WEEKDAY_W  = 3;
   localparam int TEMP_W     = 12;
   localparam int HUM_W      = 10;

   // hourly accumulators
   localparam int TSUM_W     = 18;
   localparam int HSUM_W     = 16;
   localparam int COUNT_W    = 6;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;

   // hours seen in the current day, saturating
   localparam int DAY_HOURS_W = 5;
   localparam logic [DAY_HOURS_W-1:0] DAY_HOURS_MAX = 5'd31;

   // reset value of the sample interval register
   localparam logic [MINUTE_W-1:0] INTERVAL_RESET = 6'd5;

   // default ring depth
   localparam int HOUR_SLOTS_DEF = 24;

   // weekday coding
   localparam logic [WEEKDAY_W-1:0] WD_SUNDAY   = 3'd0;
   localparam logic [WEEKDAY_W-1:0] SLOT_SUNDAY = 3'd6;

endpackage

`default_nettype wire

@@ src/shda_ifs.sv @@
`default_nettype none

// input channel: one clock reading and one sample per item
interface shda_req_if;
   logic                                valid;
   logic                                ready;
   logic [shda_pkg::MINUTE_W-1:0]       minute;
   logic [shda_pkg::HOUR_W-1:0]         hour;
   logic [shda_pkg::WEEKDAY_W-1:0]      weekday;
   logic signed [shda_pkg::TEMP_W-1:0]  temperature;
   logic [shda_pkg::HUM_W-1:0]          humidity;

   modport source (output valid, minute, hour, weekday, temperature, humidity,
                   input ready);
   modport sink   (input valid, minute, hour, weekday, temperature, humidity,
                   output ready);
endinterface

// result channel: hourly record, optionally with a daily record
interface shda_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                hour_done;
   logic [shda_pkg::HOUR_W-1:0]         hour_stamp;
   logic signed [shda_pkg::TEMP_W-1:0]  hour_temp;
   logic [shda_pkg::HUM_W-1:0]          hour_hum;
   logic                                day_done;
   logic [shda_pkg::WEEKDAY_W-1:0]      day_slot;
   logic signed [shda_pkg::TEMP_W-1:0]  day_temp;
   logic [shda_pkg::HUM_W-1:0]          day_hum;

   modport source (output valid, hour_done, hour_stamp, hour_temp, hour_hum,
                   day_done, day_slot, day_temp, day_hum,
                   input ready);
   modport sink   (input valid, hour_done, hour_stamp, hour_temp, hour_hum,
                   day_done, day_slot, day_temp, day_hum,
                   output ready);
endinterface

// configuration write channel: sample interval in minutes
interface shda_csr_if;
   logic                          valid;
   logic                          ready;
   logic [shda_pkg::MINUTE_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

@@ src/shda_ram.sv @@
`default_nettype none

module shda_ram #(
   parameter int WIDTH = 22,
   parameter int DEPTH = 24
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ src/shda_div.sv @@
`default_nettype none

module shda_div #(
   parameter int NUM_W = 18,
   parameter int DEN_W = 6
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output      logic             done,
   output      logic [NUM_W-1:0] quo
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             fits;

   // one restoring step per cycle, quotient bits shift in from the right
   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = (trial >= {1'b0, den_ff});

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[NUM_W-2:0], fits};
         rem_in = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

`default_nettype wire

@@ src/sensor_hourly_daily_averager.sv @@
// Hourly and daily temperature and humidity averager.
//
// req_bus takes one item per clock tick of the sensor: minute, hour, weekday
// and one temperature and humidity sample in tenths. rsp_bus gives at most one
// item per request, issued when the hour rolls over with samples held: the
// truncated hourly means, and when the weekday changed as well, the means of
// that day's hourly entries. csr_bus writes the sample interval in minutes;
// it is always ready and should be written only while the block is idle.
//
// Flow: a tick that closes no hour is taken in the idle state. Closing an
// hour runs the bit-serial divider (NUM_W is 18 for the default ring).
// Closing a day then walks the hourly ring in memory, newest first, one read
// per cycle over min(hours, HOUR_SLOTS) entries, and runs the divider again.
// One request is worked on at a time.
//
// Reset clears the accumulators, the clock history and the valid bits of the
// hourly ring, so the ring reads as zero until written; the interval returns
// to 5. A stalled receiver holds the result in the output register; a new
// request is still taken, and its own result waits until that one is gone.

`default_nettype none

module sensor_hourly_daily_averager #(
   parameter int HOUR_SLOTS = shda_pkg::HOUR_SLOTS_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   shda_req_if.sink   req_bus,
   shda_rsp_if.source rsp_bus,
   shda_csr_if.sink   csr_bus
);

   localparam int TEMP_W   = shda_pkg::TEMP_W;
   localparam int HUM_W    = shda_pkg::HUM_W;
   localparam int TSUM_W   = shda_pkg::TSUM_W;
   localparam int HSUM_W   = shda_pkg::HSUM_W;
   localparam int COUNT_W  = shda_pkg::COUNT_W;
   localparam int DH_W     = shda_pkg::DAY_HOURS_W;
   localparam int RING_AW  = $clog2(HOUR_SLOTS);
   localparam int RING_W   = TEMP_W + HUM_W;
   localparam int CNT_W    = $clog2(HOUR_SLOTS + 1);
   localparam int DSUM_T_W = TEMP_W + CNT_W;
   localparam int DSUM_H_W = HUM_W + CNT_W;
   localparam int NUM_A    = (TSUM_W > HSUM_W) ? TSUM_W : HSUM_W;
   localparam int NUM_B    = (DSUM_T_W > DSUM_H_W) ? DSUM_T_W : DSUM_H_W;
   localparam int NUM_W    = (NUM_A > NUM_B) ? NUM_A : NUM_B;
   localparam int DEN_W    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam int CMP_W    = (CNT_W > DH_W) ? CNT_W : DH_W;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_DIV_H = 5'b00010,
      ST_WALK  = 5'b00100,
      ST_DIV_D = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // control and accumulator state
   logic [shda_pkg::MINUTE_W-1:0]  interval_ff, interval_in;
   logic                           primed_ff, primed_in;
   logic [shda_pkg::MINUTE_W-1:0]  lsm_ff, lsm_in;
   logic [shda_pkg::HOUR_W-1:0]    lh_ff, lh_in;
   logic [shda_pkg::WEEKDAY_W-1:0] lwd_ff, lwd_in;
   logic signed [TSUM_W-1:0]       tsum_ff, tsum_in;
   logic [HSUM_W-1:0]              hsum_ff, hsum_in;
   logic [COUNT_W-1:0]             cnt_ff, cnt_in;
   logic [RING_AW-1:0]             head_ff, head_in;
   logic [DH_W-1:0]                hid_ff, hid_in;
   logic [HOUR_SLOTS-1:0]          valid_ff, valid_in;
   logic                           start_ff, start_in;
   logic                           day_chg_ff, day_chg_in;
   logic [CNT_W-1:0]               issue_ff, issue_in;
   logic                           rd_pend_ff, rd_pend_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [shda_pkg::HOUR_W-1:0]    tick_hour_ff, tick_hour_in;
   logic [shda_pkg::WEEKDAY_W-1:0] tick_wd_ff, tick_wd_in;
   logic [CNT_W-1:0]               day_n_ff, day_n_in;
   logic [RING_AW-1:0]             rd_addr_ff, rd_addr_in;
   logic                           rd_valid_ff, rd_valid_in;
   logic signed [DSUM_T_W-1:0]     day_ts_ff, day_ts_in;
   logic [DSUM_H_W-1:0]            day_hs_ff, day_hs_in;
   logic signed [TEMP_W-1:0]       res_htemp_ff, res_htemp_in;
   logic [HUM_W-1:0]               res_hhum_ff, res_hhum_in;
   logic                           res_day_ff, res_day_in;
   logic [shda_pkg::WEEKDAY_W-1:0] res_dslot_ff, res_dslot_in;
   logic signed [TEMP_W-1:0]       res_dtemp_ff, res_dtemp_in;
   logic [HUM_W-1:0]               res_dhum_ff, res_dhum_in;
   logic [shda_pkg::HOUR_W-1:0]    o_stamp_ff, o_stamp_in;
   logic signed [TEMP_W-1:0]       o_htemp_ff, o_htemp_in;
   logic [HUM_W-1:0]               o_hhum_ff, o_hhum_in;
   logic                           o_day_ff, o_day_in;
   logic [shda_pkg::WEEKDAY_W-1:0] o_dslot_ff, o_dslot_in;
   logic signed [TEMP_W-1:0]       o_dtemp_ff, o_dtemp_in;
   logic [HUM_W-1:0]               o_dhum_ff, o_dhum_in;

   // handshake
   logic req_acc;
   logic csr_acc;
   logic rsp_free;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign csr_bus.ready = 1'b1;
   assign req_acc  = req_bus.valid & req_bus.ready;
   assign csr_acc  = csr_bus.valid & csr_bus.ready;
   assign rsp_free = ~rsp_valid_ff | rsp_bus.ready;

   // sample and hour checks on the incoming item
   logic                     sample_hit;
   logic                     sample_take;
   logic signed [TSUM_W-1:0] tsum_add;
   logic [HSUM_W-1:0]        hsum_add;
   logic [COUNT_W-1:0]       cnt_add;

   assign sample_hit  = ({1'b0, req_bus.minute} ==
                         ({1'b0, lsm_ff} + {1'b0, interval_ff}));
   assign sample_take = sample_hit & (cnt_ff != shda_pkg::COUNT_MAX);
   assign tsum_add = sample_take ? tsum_ff + TSUM_W'(req_bus.temperature) : tsum_ff;
   assign hsum_add = sample_take ? hsum_ff + HSUM_W'(req_bus.humidity) : hsum_ff;
   assign cnt_add  = sample_take ? cnt_ff + COUNT_W'(1) : cnt_ff;

   // divider operands: hourly sums or the day's walk sums
   logic                    sel_day;
   logic signed [NUM_W:0]   t_ext;
   logic signed [NUM_W:0]   t_neg;
   logic                    t_sign;
   logic [NUM_W-1:0]        t_mag;
   logic [NUM_W-1:0]        h_num;
   logic [DEN_W-1:0]        den;
   logic                    t_done, h_done, div_done;
   logic [NUM_W-1:0]        t_quo, h_quo;
   logic [NUM_W-1:0]        t_quo_fix;

   assign sel_day  = (state_ff == ST_DIV_D);
   assign t_ext    = sel_day ? (NUM_W+1)'(day_ts_ff) : (NUM_W+1)'(tsum_ff);
   assign t_neg    = -t_ext;
   assign t_sign   = t_ext[NUM_W];
   assign t_mag    = t_sign ? t_neg[NUM_W-1:0] : t_ext[NUM_W-1:0];
   assign h_num    = sel_day ? NUM_W'(day_hs_ff) : NUM_W'(hsum_ff);
   assign den      = sel_day ? DEN_W'(day_n_ff) : DEN_W'(cnt_ff);
   assign div_done = t_done & h_done;
   assign t_quo_fix = t_sign ? (NUM_W'(0) - t_quo) : t_quo;

   shda_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_temp (
      .clock (clock),
      .reset (reset),
      .start (start_ff),
      .num   (t_mag),
      .den   (den),
      .done  (t_done),
      .quo   (t_quo)
   );

   shda_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_hum (
      .clock (clock),
      .reset (reset),
      .start (start_ff),
      .num   (h_num),
      .den   (den),
      .done  (h_done),
      .quo   (h_quo)
   );

   // hourly ring memory
   logic                 ram_wr_en;
   logic [RING_W-1:0]    ram_wr_data;
   logic                 ram_rd_en;
   logic [RING_W-1:0]    ram_rd_data;

   shda_ram #(.WIDTH(RING_W), .DEPTH(HOUR_SLOTS)) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (head_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_addr_ff),
      .rd_data (ram_rd_data)
   );

   assign ram_wr_data = {t_quo_fix[TEMP_W-1:0], h_quo[HUM_W-1:0]};

   // ring entry returned by the walk, zero where never written
   logic signed [TEMP_W-1:0] walk_temp;
   logic [HUM_W-1:0]         walk_hum;

   assign walk_temp = rd_valid_ff ? $signed(ram_rd_data[RING_W-1:HUM_W]) : '0;
   assign walk_hum  = rd_valid_ff ? ram_rd_data[HUM_W-1:0] : '0;

   // ring pointer arithmetic and day hour count
   logic [RING_AW-1:0] head_next;
   logic [RING_AW-1:0] rd_addr_prev;
   logic [DH_W-1:0]    hid_sat;
   logic [CMP_W-1:0]   hid_ext;
   logic [CNT_W-1:0]   day_n_new;

   assign head_next    = (head_ff == RING_AW'(HOUR_SLOTS - 1)) ? '0 : head_ff + RING_AW'(1);
   assign rd_addr_prev = (rd_addr_ff == '0) ? RING_AW'(HOUR_SLOTS - 1)
                                            : rd_addr_ff - RING_AW'(1);
   assign hid_sat   = (hid_ff == shda_pkg::DAY_HOURS_MAX) ? hid_ff : hid_ff + DH_W'(1);
   assign hid_ext   = CMP_W'(hid_sat);
   assign day_n_new = (hid_ext > CMP_W'(HOUR_SLOTS)) ? CNT_W'(HOUR_SLOTS)
                                                     : CNT_W'(hid_ext);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      interval_in  = interval_ff;
      primed_in    = primed_ff;
      lsm_in       = lsm_ff;
      lh_in        = lh_ff;
      lwd_in       = lwd_ff;
      tsum_in      = tsum_ff;
      hsum_in      = hsum_ff;
      cnt_in       = cnt_ff;
      head_in      = head_ff;
      hid_in       = hid_ff;
      valid_in     = valid_ff;
      start_in     = 1'b0;
      day_chg_in   = day_chg_ff;
      issue_in     = issue_ff;
      rd_pend_in   = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_bus.ready;
      tick_hour_in = tick_hour_ff;
      tick_wd_in   = tick_wd_ff;
      day_n_in     = day_n_ff;
      rd_addr_in   = rd_addr_ff;
      rd_valid_in  = rd_valid_ff;
      day_ts_in    = day_ts_ff;
      day_hs_in    = day_hs_ff;
      res_htemp_in = res_htemp_ff;
      res_hhum_in  = res_hhum_ff;
      res_day_in   = res_day_ff;
      res_dslot_in = res_dslot_ff;
      res_dtemp_in = res_dtemp_ff;
      res_dhum_in  = res_dhum_ff;
      o_stamp_in   = o_stamp_ff;
      o_htemp_in   = o_htemp_ff;
      o_hhum_in    = o_hhum_ff;
      o_day_in     = o_day_ff;
      o_dslot_in   = o_dslot_ff;
      o_dtemp_in   = o_dtemp_ff;
      o_dhum_in    = o_dhum_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;

      if (csr_acc) begin
         interval_in = csr_bus.data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (!primed_ff) begin
                  // first item only records the clock
                  primed_in = 1'b1;
                  lsm_in    = req_bus.minute;
                  lh_in     = req_bus.hour;
                  lwd_in    = req_bus.weekday;
               end else begin
                  tsum_in = tsum_add;
                  hsum_in = hsum_add;
                  cnt_in  = cnt_add;
                  if (sample_hit) begin
                     lsm_in = req_bus.minute;
                  end
                  if (req_bus.hour != lh_ff) begin
                     if (cnt_add == '0) begin
                        // hour change with nothing held: resync only
                        lsm_in = req_bus.minute;
                        lh_in  = req_bus.hour;
                        lwd_in = req_bus.weekday;
                     end else begin
                        lsm_in       = req_bus.minute;
                        lh_in        = req_bus.hour;
                        tick_hour_in = req_bus.hour;
                        tick_wd_in   = req_bus.weekday;
                        day_chg_in   = (req_bus.weekday != lwd_ff);
                        start_in     = 1'b1;
                        state_in     = ST_DIV_H;
                     end
                  end
               end
            end
         end

         ST_DIV_H: begin
            if (div_done) begin
               // store the hourly means and clear the accumulators
               res_htemp_in = t_quo_fix[TEMP_W-1:0];
               res_hhum_in  = h_quo[HUM_W-1:0];
               ram_wr_en    = 1'b1;
               valid_in[head_ff] = 1'b1;
               head_in      = head_next;
               tsum_in      = '0;
               hsum_in      = '0;
               cnt_in       = '0;
               if (day_chg_ff) begin
                  day_n_in     = day_n_new;
                  issue_in     = '0;
                  rd_addr_in   = head_ff;
                  day_ts_in    = '0;
                  day_hs_in    = '0;
                  res_dslot_in = (lwd_ff == shda_pkg::WD_SUNDAY) ? shda_pkg::SLOT_SUNDAY
                                 : lwd_ff - shda_pkg::WEEKDAY_W'(1);
                  lwd_in       = tick_wd_ff;
                  hid_in       = '0;
                  state_in     = ST_WALK;
               end else begin
                  hid_in       = hid_sat;
                  res_day_in   = 1'b0;
                  res_dslot_in = '0;
                  res_dtemp_in = '0;
                  res_dhum_in  = '0;
                  state_in     = ST_EMIT;
               end
            end
         end

         ST_WALK: begin
            // newest entries first, one read issued per cycle
            if (issue_ff != day_n_ff) begin
               ram_rd_en   = 1'b1;
               rd_addr_in  = rd_addr_prev;
               issue_in    = issue_ff + CNT_W'(1);
               rd_pend_in  = 1'b1;
               rd_valid_in = valid_ff[rd_addr_ff];
            end
            if (rd_pend_ff) begin
               day_ts_in = day_ts_ff + DSUM_T_W'(walk_temp);
               day_hs_in = day_hs_ff + DSUM_H_W'(walk_hum);
            end
            if ((issue_ff == day_n_ff) && !rd_pend_ff) begin
               start_in = 1'b1;
               state_in = ST_DIV_D;
            end
         end

         ST_DIV_D: begin
            if (div_done) begin
               res_day_in   = 1'b1;
               res_dtemp_in = t_quo_fix[TEMP_W-1:0];
               res_dhum_in  = h_quo[HUM_W-1:0];
               state_in     = ST_EMIT;
            end
         end

         ST_EMIT: begin
            // hand over once the output register is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               o_stamp_in   = tick_hour_ff;
               o_htemp_in   = res_htemp_ff;
               o_hhum_in    = res_hhum_ff;
               o_day_in     = res_day_ff;
               o_dslot_in   = res_dslot_ff;
               o_dtemp_in   = res_dtemp_ff;
               o_dhum_in    = res_dhum_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         interval_ff  <= shda_pkg::INTERVAL_RESET;
         primed_ff    <= 1'b0;
         lsm_ff       <= '0;
         lh_ff        <= '0;
         lwd_ff       <= '0;
         tsum_ff      <= '0;
         hsum_ff      <= '0;
         cnt_ff       <= '0;
         head_ff      <= '0;
         hid_ff       <= '0;
         valid_ff     <= '0;
         start_ff     <= 1'b0;
         day_chg_ff   <= 1'b0;
         issue_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         interval_ff  <= interval_in;
         primed_ff    <= primed_in;
         lsm_ff       <= lsm_in;
         lh_ff        <= lh_in;
         lwd_ff       <= lwd_in;
         tsum_ff      <= tsum_in;
         hsum_ff      <= hsum_in;
         cnt_ff       <= cnt_in;
         head_ff      <= head_in;
         hid_ff       <= hid_in;
         valid_ff     <= valid_in;
         start_ff     <= start_in;
         day_chg_ff   <= day_chg_in;
         issue_ff     <= issue_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      tick_hour_ff <= tick_hour_in;
      tick_wd_ff   <= tick_wd_in;
      day_n_ff     <= day_n_in;
      rd_addr_ff   <= rd_addr_in;
      rd_valid_ff  <= rd_valid_in;
      day_ts_ff    <= day_ts_in;
      day_hs_ff    <= day_hs_in;
      res_htemp_ff <= res_htemp_in;
      res_hhum_ff  <= res_hhum_in;
      res_day_ff   <= res_day_in;
      res_dslot_ff <= res_dslot_in;
      res_dtemp_ff <= res_dtemp_in;
      res_dhum_ff  <= res_dhum_in;
      o_stamp_ff   <= o_stamp_in;
      o_htemp_ff   <= o_htemp_in;
      o_hhum_ff    <= o_hhum_in;
      o_day_ff     <= o_day_in;
      o_dslot_ff   <= o_dslot_in;
      o_dtemp_ff   <= o_dtemp_in;
      o_dhum_ff    <= o_dhum_in;
   end

   // result port
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.hour_done  = 1'b1;
   assign rsp_bus.hour_stamp = o_stamp_ff;
   assign rsp_bus.hour_temp  = o_htemp_ff;
   assign rsp_bus.hour_hum   = o_hhum_ff;
   assign rsp_bus.day_done   = o_day_ff;
   assign rsp_bus.day_slot   = o_dslot_ff;
   assign rsp_bus.day_temp   = o_dtemp_ff;
   assign rsp_bus.day_hum    = o_dhum_ff;

endmodule

`default_nettype wire

@@ src/shda_checker.sv @@
`default_nettype none

module shda_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_valid,
   input wire logic                               req_ready,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_ready,
   input wire logic                               rsp_hour_done,
   input wire logic [shda_pkg::HOUR_W-1:0]        rsp_hour_stamp,
   input wire logic                               rsp_day_done,
   input wire logic [shda_pkg::WEEKDAY_W-1:0]     rsp_day_slot,
   input wire logic [shda_pkg::TEMP_W-1:0]        rsp_day_temp,
   input wire logic [shda_pkg::HUM_W-1:0]         rsp_day_hum
);

   // a stalled result keeps its valid and its hour stamp
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hour_stamp))
      else $error("stalled result dropped or changed");

   // every result carries an hourly record
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hour_done)
      else $error("result without hourly record");

   // day fields are zero unless a daily record is reported
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_day_done |->
         rsp_day_slot == '0 && rsp_day_temp == '0 && rsp_day_hum == '0)
      else $error("day fields set without daily record");

   // a result never appears right after an item was taken
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
      else $error("result too soon after item");

   // no result is pending right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind sensor_hourly_daily_averager shda_checker u_shda_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_hour_done  (rsp_bus.hour_done),
   .rsp_hour_stamp (rsp_bus.hour_stamp),
   .rsp_day_done   (rsp_bus.day_done),
   .rsp_day_slot   (rsp_bus.day_slot),
   .rsp_day_temp   (rsp_bus.day_temp),
   .rsp_day_hum    (rsp_bus.day_hum)
);

`default_nettype wire
